// ===== rtl/trsf_pkg.sv =====
package trsf_pkg;

  // Widest value that a byte offset or a length can take.
  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  // Largest number of section types that configuration can name.
  localparam int unsigned MAX_SEQ_TYPES = 8;

  // Number of bytes in a little-endian length field.
  localparam int unsigned LEN_FIELD_BYTES = 4;

  // Configuration register indexes.
  localparam logic CFG_SEQ_TYPES  = 1'b0;
  localparam logic CFG_SEQ_LENGTH = 1'b1;

  // Section type characters.
  localparam logic [7:0] CHR_NUL = 8'h00;
  localparam logic [7:0] CHR_M   = 8'h6d;
  localparam logic [7:0] CHR_T   = 8'h74;
  localparam logic [7:0] CHR_Y   = 8'h79;
  localparam logic [7:0] CHR_L   = 8'h6c;
  localparam logic [7:0] CHR_G   = 8'h67;
  localparam logic [7:0] CHR_X   = 8'h78;
  localparam logic [7:0] CHR_K   = 8'h6b;
  localparam logic [7:0] CHR_H   = 8'h68;
  localparam logic [7:0] CHR_UW  = 8'h57;
  localparam logic [7:0] CHR_UP  = 8'h50;
  localparam logic [7:0] CHR_UA  = 8'h41;
  localparam logic [7:0] CHR_UZ  = 8'h5a;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN_TEXT,
    PH_LEN_SKIP,
    PH_SKIP_LEN,
    PH_SKIP_NUL,
    PH_FOUND,
    PH_FAIL
  } phase_e;

  // Effective type sequence as seen by the parser.
  typedef struct packed {
    logic [3:0]  count;
    logic [63:0] types;
  } seq_cfg_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic        found;
    logic [7:0]  typ;
  } result_t;

  // Text types that end at the first NUL.
  function automatic logic is_text(logic [7:0] t);
    return (t == CHR_M) || (t == CHR_T) || (t == CHR_Y) || (t == CHR_L) ||
           (t == CHR_G) || (t == CHR_X) || (t == CHR_K);
  endfunction

  // Text types that carry a length field.
  function automatic logic is_sized(logic [7:0] t);
    return (t == CHR_H) || (t == CHR_UW) || (t == CHR_UP);
  endfunction

endpackage

// ===== rtl/trsf_cfg.sv =====
module trsf_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output trsf_pkg::seq_cfg_t seq_cfg_o
);

  logic [63:0] seq_types_q;
  logic [3:0]  seq_len_q;
  logic [3:0]  len_lim;
  logic [3:0]  count;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_types_q <= '0;
      seq_len_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        trsf_pkg::CFG_SEQ_TYPES:  seq_types_q <= cfg_data_i;
        trsf_pkg::CFG_SEQ_LENGTH: seq_len_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // The sequence is clamped to its maximum and ends at the first zero type.
  always_comb begin
    len_lim = (seq_len_q > 4'(trsf_pkg::MAX_SEQ_TYPES)) ?
              4'(trsf_pkg::MAX_SEQ_TYPES) : seq_len_q;
    count = len_lim;
    for (int i = trsf_pkg::MAX_SEQ_TYPES - 1; i >= 0; i--) begin
      if ((4'(i) < len_lim) && (seq_types_q[8*i +: 8] == trsf_pkg::CHR_NUL)) begin
        count = 4'(i);
      end
    end
  end

  assign seq_cfg_o.count = count;
  assign seq_cfg_o.types = seq_types_q;

endmodule

// ===== rtl/trsf_parse.sv =====
module trsf_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               in_stall_o,
  input  trsf_pkg::seq_cfg_t seq_cfg_i,
  input  logic               res_ready_i,
  output logic               res_load_o,
  output trsf_pkg::result_t  res_o
);

  // Per-section parse state.
  typedef struct packed {
    trsf_pkg::phase_e phase;
    logic [3:0]       idx;
    logic [31:0]      acc;
    logic [1:0]       cnt;
    logic [31:0]      skip;
    logic [31:0]      start;
    logic [31:0]      limit;
    logic [7:0]       typ;
  } st_t;

  // Input register.
  logic        in_valid_q;
  logic [7:0]  data_q;
  logic        last_q;

  // Record state.
  st_t         st_q;
  logic [31:0] pos_q;
  logic [31:0] nul_pos_q;
  logic        nul_seen_q;
  logic        sent_q;

  // Step logic.
  st_t         st_a;
  st_t         st_b;
  st_t         st_c;
  logic [31:0] pos_inc;
  logic [32:0] lim_sum;
  logic [31:0] acc_or;
  logic        is_nul;
  logic [31:0] nul_pos_n;
  logic        nul_seen_n;
  logic        final_c;
  logic        emit;
  logic        found;
  logic [31:0] end_pos;
  logic [31:0] found_len;
  logic        accept;
  logic        fire;

  // Open a section of type t whose data starts at the given offset.
  function automatic st_t begin_f(st_t s, logic [7:0] t, logic [31:0] start);
    st_t r;
    r     = s;
    r.acc = '0;
    r.cnt = '0;
    if (trsf_pkg::is_text(t)) begin
      r.typ   = t;
      r.start = start;
      r.limit = trsf_pkg::POS_MAX;
      r.phase = trsf_pkg::PH_FOUND;
    end else if (trsf_pkg::is_sized(t)) begin
      r.typ   = t;
      r.phase = trsf_pkg::PH_LEN_TEXT;
    end else if ((t >= trsf_pkg::CHR_UA) && (t <= trsf_pkg::CHR_UZ)) begin
      r.phase = trsf_pkg::PH_LEN_SKIP;
    end else begin
      r.phase = trsf_pkg::PH_SKIP_NUL;
    end
    return r;
  endfunction

  // A skipped section is over: wait for the next type.
  function automatic st_t done_f(st_t s);
    st_t r;
    r       = s;
    r.phase = trsf_pkg::PH_TYPE;
    if (s.idx != 4'hF) begin
      r.idx = s.idx + 4'd1;
    end
    return r;
  endfunction

  // In sequence mode, take the next type from configuration.
  function automatic st_t resolve_f(st_t s, logic [31:0] pos, trsf_pkg::seq_cfg_t c);
    st_t        r;
    logic [7:0] t;
    r = s;
    t = c.types[{s.idx[2:0], 3'b000} +: 8];
    if ((c.count != 4'd0) && (s.phase == trsf_pkg::PH_TYPE)) begin
      if (s.idx >= c.count) begin
        r.phase = trsf_pkg::PH_FAIL;
      end else if (!trsf_pkg::is_text(t) && !trsf_pkg::is_sized(t) &&
                   ((s.idx + 4'd1) == c.count)) begin
        r.phase = trsf_pkg::PH_FAIL;
      end else begin
        r = begin_f(s, t, pos);
      end
    end
    return r;
  endfunction

  // One record byte: resolve, consume, resolve again.
  always_comb begin
    is_nul  = (data_q == trsf_pkg::CHR_NUL);
    pos_inc = (pos_q == trsf_pkg::POS_MAX) ? pos_q : pos_q + 32'd1;
    acc_or  = '0;
    lim_sum = '0;

    st_a = resolve_f(st_q, pos_q, seq_cfg_i);
    st_b = st_a;
    case (st_a.phase)
      trsf_pkg::PH_TYPE: begin
        st_b = begin_f(st_a, data_q, pos_inc);
      end
      trsf_pkg::PH_LEN_TEXT, trsf_pkg::PH_LEN_SKIP: begin
        acc_or   = st_a.acc | ({24'd0, data_q} << {st_a.cnt, 3'b000});
        st_b.acc = acc_or;
        st_b.cnt = st_a.cnt + 2'd1;
        if (st_a.cnt == 2'(trsf_pkg::LEN_FIELD_BYTES - 1)) begin
          st_b.cnt = '0;
          if (st_a.phase == trsf_pkg::PH_LEN_TEXT) begin
            lim_sum    = {1'b0, pos_inc} + {1'b0, acc_or};
            st_b.start = pos_inc;
            st_b.limit = lim_sum[32] ? trsf_pkg::POS_MAX : lim_sum[31:0];
            st_b.phase = trsf_pkg::PH_FOUND;
          end else if (acc_or == 32'd0) begin
            st_b = done_f(st_b);
          end else begin
            st_b.skip  = acc_or;
            st_b.phase = trsf_pkg::PH_SKIP_LEN;
          end
        end
      end
      trsf_pkg::PH_SKIP_LEN: begin
        if (st_a.skip != 32'd0) begin
          st_b.skip = st_a.skip - 32'd1;
        end
        if (st_a.skip <= 32'd1) begin
          st_b = done_f(st_b);
        end
      end
      trsf_pkg::PH_SKIP_NUL: begin
        if (is_nul) begin
          st_b = done_f(st_a);
        end
      end
      trsf_pkg::PH_FOUND: begin
        // Cut the chosen section at its first NUL.
        if ((st_a.cnt == 2'd0) && is_nul && (pos_q >= st_a.start) &&
            (pos_q < st_a.limit)) begin
          st_b.limit = pos_q;
          st_b.cnt   = 2'd1;
        end
      end
      default: ;
    endcase
    st_c = resolve_f(st_b, pos_inc, seq_cfg_i);

    // First NUL of the whole record.
    nul_seen_n = nul_seen_q | is_nul;
    nul_pos_n  = (is_nul && !nul_seen_q) ? pos_q : nul_pos_q;

    // Final once cut or fully passed, or on FAIL once a NUL is seen.
    if (st_c.phase == trsf_pkg::PH_FOUND) begin
      final_c = (st_c.cnt == 2'd1) ||
                (!trsf_pkg::is_text(st_c.typ) && (st_c.limit <= pos_inc));
    end else begin
      final_c = (st_c.phase == trsf_pkg::PH_FAIL) && nul_seen_n;
    end
    emit = !sent_q && (last_q || final_c);

    // A middle text section with no NUL falls back to the whole record.
    found = (st_c.phase == trsf_pkg::PH_FOUND) &&
            !((seq_cfg_i.count != 4'd0) && trsf_pkg::is_text(st_c.typ) &&
              (({1'b0, st_c.idx} + 5'd1) < {1'b0, seq_cfg_i.count}) &&
              (st_c.cnt == 2'd0));
    end_pos   = (st_c.limit < pos_inc) ? st_c.limit : pos_inc;
    found_len = (end_pos > st_c.start) ? end_pos - st_c.start : 32'd0;

    if (found) begin
      res_o.start  = st_c.start;
      res_o.length = found_len;
      res_o.found  = 1'b1;
      res_o.typ    = st_c.typ;
    end else begin
      res_o.start  = '0;
      res_o.length = nul_seen_n ? nul_pos_n : pos_inc;
      res_o.found  = 1'b0;
      res_o.typ    = '0;
    end
  end

  // A byte steps unless its result finds the output register still full.
  assign fire       = in_valid_q && (!emit || res_ready_i);
  assign res_load_o = fire && emit;
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // Record state; the last byte of a record returns everything to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      pos_q      <= '0;
      nul_pos_q  <= '0;
      nul_seen_q <= 1'b0;
      sent_q     <= 1'b0;
    end else if (fire) begin
      if (last_q) begin
        st_q       <= '0;
        pos_q      <= '0;
        nul_pos_q  <= '0;
        nul_seen_q <= 1'b0;
        sent_q     <= 1'b0;
      end else begin
        st_q       <= st_c;
        pos_q      <= pos_inc;
        nul_pos_q  <= nul_pos_n;
        nul_seen_q <= nul_seen_n;
        sent_q     <= sent_q | emit;
      end
    end
  end

endmodule

// ===== rtl/trsf_out.sv =====
module trsf_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_load_i,
  input  trsf_pkg::result_t res_i,
  output logic              res_ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       section_start_o,
  output logic [31:0]       section_length_o,
  output logic              section_found_o,
  output logic [7:0]        section_type_o
);

  logic              out_valid_q;
  trsf_pkg::result_t res_q;

  // The register can take a new result when it is empty or being emptied.
  assign res_ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign section_start_o  = res_q.start;
  assign section_length_o = res_q.length;
  assign section_found_o  = res_q.found;
  assign section_type_o   = res_q.typ;

endmodule

// ===== rtl/typed_record_text_section_finder.sv =====
// Each byte passes the input register; a result it settles then loads the result register.
// Throughput: one record byte per cycle; a byte waits only when it settles a result
// while the single output register still holds an earlier, stalled result.
// At most one result per record, given when the section is settled or on the last byte.
// Reset (asynchronous, active low) clears the parser, both registers of the pipeline
// and the configuration, which then selects mixed mode.
module typed_record_text_section_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] section_start_o,
  output logic [31:0] section_length_o,
  output logic        section_found_o,
  output logic [7:0]  section_type_o
);

  trsf_pkg::seq_cfg_t seq_cfg;
  trsf_pkg::result_t  res;
  logic               res_load;
  logic               res_ready;

  // Configuration registers and the effective type sequence.
  trsf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .seq_cfg_o  (seq_cfg)
  );

  // Input register and the byte parser.
  trsf_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .in_stall_o (in_stall_o),
    .seq_cfg_i  (seq_cfg),
    .res_ready_i(res_ready),
    .res_load_o (res_load),
    .res_o      (res)
  );

  // Result register.
  trsf_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_load_i      (res_load),
    .res_i           (res),
    .res_ready_o     (res_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .section_start_o (section_start_o),
    .section_length_o(section_length_o),
    .section_found_o (section_found_o),
    .section_type_o  (section_type_o)
  );

endmodule
